// File: rtl/simple_interrupt_controller_assert.svh
// Assertion macros shared by the controller RTL.
`ifndef SIMPLE_INTERRUPT_CONTROLLER_ASSERT_SVH
`define SIMPLE_INTERRUPT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SIC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define SIC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sic_pkg.sv
package sic_pkg;

   localparam int NUM_SOURCES = 32;
   localparam int WORD_W      = 24;
   localparam int CTX_MAX_W   = 5;

   localparam logic [1:0] REQ_READ   = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_UPDATE = 2'd2;

   localparam logic [1:0] SIZE_WORD    = 2'd2;
   localparam logic [1:0] SIZE_ILLEGAL = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FAULT    = 2'd1;
   localparam logic [1:0] ST_MISALIGN = 2'd2;
   localparam logic [1:0] ST_ILLEGAL  = 2'd3;

   localparam logic [WORD_W-1:0] PENDING_WORD = 24'h000400;
   localparam logic [WORD_W-1:0] ENABLE_BASE  = 24'h000800;
   localparam logic [WORD_W-1:0] CONTEXT_BASE = 24'h080000;
   localparam int ENABLE_STRIDE_LOG  = 5;
   localparam int CONTEXT_STRIDE_LOG = 10;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [25:0] addr;
      logic [1:0]  size;
      logic [31:0] wdata;
      logic [31:0] active_sources;
   } req_data_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic [1:0]  status;
      logic [31:0] sei_lines;
   } rsp_data_type;

   typedef logic [5:0] csr_data_type;

   typedef struct packed {
      logic                 hit_prio;
      logic                 hit_pending;
      logic                 hit_enable;
      logic                 hit_thresh;
      logic                 hit_claim;
      logic [CTX_MAX_W-1:0] ctx;
   } decode_type;

   // Index of the lowest set bit; 0 when none.
   function automatic logic [4:0] lowest_id(input logic [NUM_SOURCES-1:0] v);
      logic [NUM_SOURCES-1:0] iso;
      logic [4:0]             id;
      iso = v & (~v + 32'd1);
      id  = '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         if (iso[i]) begin
            id = id | 5'(i);
         end
      end
      return id;
   endfunction

endpackage

// File: rtl/sic_chan_if.sv
interface sic_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sic_decode.sv
module sic_decode #(
   parameter int NUM_CONTEXTS = 32
) (
   input  logic [sic_pkg::WORD_W-1:0] word,
   output sic_pkg::decode_type        dec
);

   logic [sic_pkg::WORD_W-1:0] enable_off;
   logic [sic_pkg::WORD_W-1:0] ctx_off;
   logic [sic_pkg::WORD_W-sic_pkg::ENABLE_STRIDE_LOG-1:0]  enable_ctx;
   logic [sic_pkg::WORD_W-sic_pkg::CONTEXT_STRIDE_LOG-1:0] ctx_idx;
   logic [sic_pkg::CONTEXT_STRIDE_LOG-1:0]                 ctx_reg;
   logic in_ctx;

   assign enable_off = word - sic_pkg::ENABLE_BASE;
   assign ctx_off    = word - sic_pkg::CONTEXT_BASE;
   assign enable_ctx = enable_off[sic_pkg::WORD_W-1:sic_pkg::ENABLE_STRIDE_LOG];
   assign ctx_idx    = ctx_off[sic_pkg::WORD_W-1:sic_pkg::CONTEXT_STRIDE_LOG];
   assign ctx_reg    = ctx_off[sic_pkg::CONTEXT_STRIDE_LOG-1:0];

   assign in_ctx = (word >= sic_pkg::CONTEXT_BASE) &&
                   (ctx_reg[sic_pkg::CONTEXT_STRIDE_LOG-1:1] == '0) &&
                   (ctx_idx < (sic_pkg::WORD_W-sic_pkg::CONTEXT_STRIDE_LOG)'(NUM_CONTEXTS));

   always_comb begin
      dec.hit_prio    = (word != '0) && (word[sic_pkg::WORD_W-1:5] == '0);
      dec.hit_pending = (word == sic_pkg::PENDING_WORD);
      dec.hit_enable  = (word >= sic_pkg::ENABLE_BASE) &&
                        (enable_off[sic_pkg::ENABLE_STRIDE_LOG-1:0] == '0) &&
                        (enable_ctx <
                         (sic_pkg::WORD_W-sic_pkg::ENABLE_STRIDE_LOG)'(NUM_CONTEXTS));
      dec.hit_thresh  = in_ctx && !ctx_reg[0];
      dec.hit_claim   = in_ctx && ctx_reg[0];
      dec.ctx         = dec.hit_enable ? enable_ctx[sic_pkg::CTX_MAX_W-1:0]
                                       : ctx_idx[sic_pkg::CTX_MAX_W-1:0];
   end

endmodule

// File: rtl/simple_interrupt_controller.sv
// Simple interrupt controller: 32 sources, no priorities, NUM_CONTEXTS contexts.
// req_chan takes one beat per bus read, bus write or update event (req_type).
// rsp_chan returns exactly one beat per request, in order: rdata, status and,
// for an update event, the per-hart external interrupt / wake lines.
// csr_chan writes num_harts (6 bits); it is always ready and must only be
// written while no request is outstanding.
// A request accepted into the input register is decoded from there and applied to
// the state as its response is registered, which is then valid until taken.
// Throughput: one request per cycle while responses are taken; set by the single input
// register and result register around the decode, claim search and line OR logic.
// When rsp_ready is low the response holds; one more request can sit in the
// input register, after which req_ready drops.
// Reset (synchronous, active high): pending, in-service and enable words
// clear, num_harts returns to 1, both registers empty.
module simple_interrupt_controller #(
   parameter int NUM_CONTEXTS = 32
) (
   input logic         clock,
   input logic         reset,
   sic_chan_if.sink    req_chan,
   sic_chan_if.source  rsp_chan,
   sic_chan_if.sink    csr_chan
);

   localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

   logic                  in_valid_ff, in_valid_in;
   logic                  out_valid_ff, out_valid_in;
   sic_pkg::req_data_type req_ff;
   sic_pkg::rsp_data_type rsp_ff, rsp_in;
   logic [5:0]            num_harts_ff;
   logic [31:0]           pending_ff, pending_in;
   logic [31:0]           in_service_ff, in_service_in;
   logic [31:0]           enable_ff [NUM_CONTEXTS];

   logic                  process;
   logic                  en_we;
   logic [CTX_W-1:0]      ctx_idx;
   logic [31:0]           en_word;
   logic [31:0]           cand;
   logic [4:0]            claim_id;
   sic_pkg::decode_type   dec;

   sic_decode #(.NUM_CONTEXTS(NUM_CONTEXTS)) u_decode (
      .word (req_ff.addr[25:2]),
      .dec  (dec)
   );

   assign process        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || process;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   assign ctx_idx  = dec.ctx[CTX_W-1:0];
   assign en_word  = enable_ff[ctx_idx];
   assign cand     = pending_ff & en_word;
   assign claim_id = sic_pkg::lowest_id(cand);

   assign in_valid_in  = (req_chan.valid && req_chan.ready) ? 1'b1
                                                            : (process ? 1'b0 : in_valid_ff);
   assign out_valid_in = process ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_comb begin
      rsp_in        = '0;
      pending_in    = pending_ff;
      in_service_in = in_service_ff;
      en_we         = 1'b0;
      if (process) begin
         case (req_ff.req_type)
            sic_pkg::REQ_READ, sic_pkg::REQ_WRITE: begin
               if (req_ff.size == sic_pkg::SIZE_WORD) begin
                  if (req_ff.req_type == sic_pkg::REQ_READ) begin
                     if (dec.hit_prio || dec.hit_thresh) begin
                        rsp_in.status = sic_pkg::ST_OK;
                     end else if (dec.hit_pending) begin
                        rsp_in.rdata = pending_ff;
                     end else if (dec.hit_enable) begin
                        rsp_in.rdata = en_word;
                     end else if (dec.hit_claim) begin
                        if (cand != '0) begin
                           rsp_in.rdata           = {27'd0, claim_id};
                           pending_in[claim_id]   = 1'b0;
                        end
                     end else begin
                        rsp_in.status = sic_pkg::ST_FAULT;
                     end
                  end else begin
                     if (dec.hit_prio || dec.hit_thresh) begin
                        rsp_in.status = sic_pkg::ST_OK;
                     end else if (dec.hit_enable) begin
                        en_we = 1'b1;
                     end else if (dec.hit_claim) begin
                        if ((req_ff.wdata[31:5] == '0) && en_word[req_ff.wdata[4:0]]) begin
                           in_service_in[req_ff.wdata[4:0]] = 1'b0;
                        end
                     end else begin
                        rsp_in.status = sic_pkg::ST_FAULT;
                     end
                  end
               end else if (req_ff.size == sic_pkg::SIZE_ILLEGAL) begin
                  rsp_in.status = sic_pkg::ST_ILLEGAL;
               end else begin
                  rsp_in.status = sic_pkg::ST_MISALIGN;
               end
            end
            sic_pkg::REQ_UPDATE: begin
               pending_in    = pending_ff | (req_ff.active_sources & ~in_service_ff);
               in_service_in = in_service_ff | req_ff.active_sources;
               for (int h = 0; h < NUM_CONTEXTS; h++) begin
                  rsp_in.sei_lines[h] = (6'(h) < num_harts_ff) &&
                                        ((pending_in & enable_ff[h]) != '0);
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         num_harts_ff  <= 6'd1;
         pending_ff    <= '0;
         in_service_ff <= '0;
         for (int c = 0; c < NUM_CONTEXTS; c++) begin
            enable_ff[c] <= '0;
         end
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         pending_ff    <= pending_in;
         in_service_ff <= in_service_in;
         if (csr_chan.valid) begin
            num_harts_ff <= csr_chan.data;
         end
         if (en_we) begin
            enable_ff[ctx_idx] <= {req_ff.wdata[31:1], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_ff <= req_chan.data;
      end
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

`include "simple_interrupt_controller_assert.svh"

   `SIC_ASSERT_NOW(a_no_overwrite, out_valid_ff && !rsp_chan.ready, !process, "response overwritten while stalled")
   `SIC_ASSERT_NEXT(a_result_follows, process, out_valid_ff, "processed request gave no response")
   `SIC_ASSERT_NOW(a_lines_ok, out_valid_ff && (rsp_ff.sei_lines != '0), rsp_ff.status == sic_pkg::ST_OK, "interrupt lines with error status")

endmodule

// File: dv/tb_simple_interrupt_controller.sv
module tb_simple_interrupt_controller;

   localparam int NUM_CTX = 32;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_HALF  = 2'd1;
   localparam int PHASE_BEATS = 230;
   localparam int HOLD_OFF_CYCLES = 100;

   typedef struct {
      sic_pkg::req_data_type req;
      bit                    pinned;
      sic_pkg::rsp_data_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   sic_chan_if #(.payload_type(sic_pkg::req_data_type)) req_if ();
   sic_chan_if #(.payload_type(sic_pkg::rsp_data_type)) rsp_if ();
   sic_chan_if #(.payload_type(sic_pkg::csr_data_type)) csr_if ();

   simple_interrupt_controller #(.NUM_CONTEXTS(NUM_CTX)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Controller state as predicted
   logic [31:0]           pend_bits;
   logic [31:0]           svc_bits;
   logic [31:0]           enab_words [NUM_CTX];
   sic_pkg::csr_data_type hart_count;

   sic_pkg::rsp_data_type rsp_due_q [$];
   int                    err_count;

   // Typed-in expectation that travels with the beat on the request channel
   bit                    drv_pinned;
   sic_pkg::rsp_data_type drv_pinned_rsp;

   bit gaps_on;
   bit hold_off_req;

   stim_row_type dir_rows [$];

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic sic_pkg::rsp_data_type sic_response(input sic_pkg::req_data_type r);
      sic_pkg::rsp_data_type o;
      logic [23:0]  w;
      logic [23:0]  eoff;
      logic [23:0]  coff;
      logic         enab_hit;
      logic         ctx_hit;
      logic [4:0]   eidx;
      logic [4:0]   cidx;
      logic [31:0]  cand;
      logic [4:0]   id;
      int           limit;
      o = '0;
      w = r.addr[25:2];
      eoff = w - sic_pkg::ENABLE_BASE;
      enab_hit = (w >= sic_pkg::ENABLE_BASE) && (eoff[4:0] == '0) && (eoff[23:5] < NUM_CTX);
      eidx = eoff[9:5];
      coff = w - sic_pkg::CONTEXT_BASE;
      ctx_hit = (w >= sic_pkg::CONTEXT_BASE) && (coff[9:1] == '0) && (coff[23:10] < NUM_CTX);
      cidx = coff[14:10];
      case (r.req_type)
         sic_pkg::REQ_READ, sic_pkg::REQ_WRITE: begin
            if (r.size == sic_pkg::SIZE_WORD) begin
               if (w >= 24'd1 && w <= 24'd31) begin
                  o.status = sic_pkg::ST_OK;
               end else if (r.req_type == sic_pkg::REQ_READ && w == sic_pkg::PENDING_WORD) begin
                  o.rdata = pend_bits;
               end else if (enab_hit) begin
                  if (r.req_type == sic_pkg::REQ_READ) begin
                     o.rdata = enab_words[eidx];
                  end else begin
                     enab_words[eidx] = r.wdata & ~32'd1;
                  end
               end else if (ctx_hit) begin
                  if (coff[0]) begin
                     if (r.req_type == sic_pkg::REQ_READ) begin
                        cand = pend_bits & enab_words[cidx];
                        if (cand != '0) begin
                           id = '0;
                           for (int i = 31; i >= 0; i--) begin
                              if (cand[i]) begin
                                 id = 5'(i);
                              end
                           end
                           o.rdata = 32'(id);
                           pend_bits[id] = 1'b0;
                        end
                     end else if (r.wdata < 32 && enab_words[cidx][r.wdata[4:0]]) begin
                        svc_bits[r.wdata[4:0]] = 1'b0;
                     end
                  end
               end else begin
                  o.status = sic_pkg::ST_FAULT;
               end
            end else if (r.size == sic_pkg::SIZE_ILLEGAL) begin
               o.status = sic_pkg::ST_ILLEGAL;
            end else begin
               o.status = sic_pkg::ST_MISALIGN;
            end
         end
         sic_pkg::REQ_UPDATE: begin
            pend_bits = pend_bits | (r.active_sources & ~svc_bits);
            svc_bits  = svc_bits | r.active_sources;
            limit = (hart_count > NUM_CTX) ? NUM_CTX : int'(hart_count);
            for (int h = 0; h < limit; h++) begin
               if ((pend_bits & enab_words[h]) != '0) begin
                  o.sei_lines[h] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   // Beat monitor: responses are checked before the request of the same edge is queued
   always @(posedge clock) begin
      sic_pkg::rsp_data_type want;
      if (reset) begin
         pend_bits  <= '0;
         svc_bits   <= '0;
         hart_count <= 6'd1;
         for (int i = 0; i < NUM_CTX; i++) begin
            enab_words[i] <= '0;
         end
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (rsp_due_q.size() == 0) begin
               $error("response beat with nothing outstanding: %p", rsp_if.data);
               err_count++;
            end else begin
               want = rsp_due_q.pop_front();
               if (rsp_if.data.rdata !== want.rdata) begin
                  $error("rdata: expected %h, actual %h", want.rdata, rsp_if.data.rdata);
                  err_count++;
               end
               if (rsp_if.data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_if.data.status);
                  err_count++;
               end
               if (rsp_if.data.sei_lines !== want.sei_lines) begin
                  $error("sei_lines: expected %h, actual %h", want.sei_lines,
                         rsp_if.data.sei_lines);
                  err_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = sic_response(req_if.data);
            rsp_due_q.push_back(drv_pinned ? drv_pinned_rsp : want);
         end
         if (csr_if.valid && csr_if.ready) begin
            hart_count = csr_if.data;
         end
      end
   end

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (!gaps_on || sel < 55) begin
         return 0;
      end else if (sel < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 25);
   endfunction

   // Response side back-pressure
   initial begin
      int sel;
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0) begin
         @(negedge clock);
      end
      forever begin
         sel = $urandom_range(0, 99);
         if (hold_off_req) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (!gaps_on || sel < 65) begin
            rsp_if.ready = 1'b1;
            @(negedge clock);
         end else begin
            rsp_if.ready = 1'b0;
            repeat ((sel < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(negedge clock);
         end
      end
   end

   task automatic send_beat(input sic_pkg::req_data_type beat, input bit pin,
                            input sic_pkg::rsp_data_type want, input int gap);
      @(negedge clock);
      req_if.valid   = 1'b1;
      req_if.data    = beat;
      drv_pinned     = pin;
      drv_pinned_rsp = want;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (rsp_due_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_harts(input sic_pkg::csr_data_type v);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.data  = v;
      do begin
         @(posedge clock);
      end while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   function automatic logic [25:0] enable_addr(input int c);
      return {24'(sic_pkg::ENABLE_BASE + 24'(c << sic_pkg::ENABLE_STRIDE_LOG)), 2'b00};
   endfunction

   function automatic logic [25:0] ctx_addr(input int c, input int sel);
      return {24'(sic_pkg::CONTEXT_BASE + 24'(c << sic_pkg::CONTEXT_STRIDE_LOG) + 24'(sel)),
              2'b00};
   endfunction

   function automatic stim_row_type row(input logic [1:0] t, input logic [25:0] a,
                                        input logic [1:0] s, input logic [31:0] wd,
                                        input logic [31:0] act, input bit pin,
                                        input logic [31:0] rd, input logic [1:0] st,
                                        input logic [31:0] sei);
      stim_row_type x;
      x.req.req_type       = t;
      x.req.addr           = a;
      x.req.size           = s;
      x.req.wdata          = wd;
      x.req.active_sources = act;
      x.pinned             = pin;
      x.rsp.rdata          = rd;
      x.rsp.status         = st;
      x.rsp.sei_lines      = sei;
      return x;
   endfunction

   function automatic int pick_ctx();
      return ($urandom_range(0, 99) < 90) ? $urandom_range(0, 31) : $urandom_range(32, 63);
   endfunction

   function automatic sic_pkg::req_data_type random_beat();
      sic_pkg::req_data_type r;
      int           sel;
      logic [23:0]  w;
      r.req_type       = sic_pkg::REQ_READ;
      r.size           = sic_pkg::SIZE_WORD;
      r.wdata          = $urandom;
      r.active_sources = $urandom;
      w = '0;
      sel = $urandom_range(0, 99);
      if (sel < 16) begin
         r.req_type = sic_pkg::REQ_UPDATE;
         case ($urandom_range(0, 3))
            0: r.active_sources = $urandom;
            1: r.active_sources = 32'd1 << $urandom_range(0, 31);
            2: r.active_sources = $urandom & $urandom & $urandom;
            default: r.active_sources = '1;
         endcase
         r.addr = 26'($urandom);
         r.size = 2'($urandom);
         return r;
      end else if (sel < 40) begin
         w = 24'(ctx_addr(pick_ctx(), 1) >> 2);
      end else if (sel < 55) begin
         r.req_type = sic_pkg::REQ_WRITE;
         w = 24'(ctx_addr(pick_ctx(), 1) >> 2);
         if ($urandom_range(0, 99) >= 30) begin
            r.wdata = $urandom_range(0, 31);
         end
      end else if (sel < 68) begin
         r.req_type = sic_pkg::REQ_WRITE;
         w = 24'(enable_addr(pick_ctx()) >> 2);
      end else if (sel < 76) begin
         w = 24'(enable_addr(pick_ctx()) >> 2);
      end else if (sel < 82) begin
         w = sic_pkg::PENDING_WORD;
      end else if (sel < 88) begin
         r.req_type = 2'($urandom_range(0, 1));
         w = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 32))
                                           : 24'(ctx_addr(pick_ctx(), 0) >> 2);
      end else begin
         r.req_type = 2'($urandom);
         r.addr     = 26'($urandom);
         r.size     = 2'($urandom);
         return r;
      end
      r.addr = {w, 2'($urandom)};
      if ($urandom_range(0, 99) < 5) begin
         r.size = 2'($urandom);
      end
      return r;
   endfunction

   initial begin
      sic_pkg::csr_data_type harts_plan [6];
      sic_pkg::req_data_type beat;
      sic_pkg::rsp_data_type none;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.data     = '0;
      csr_if.valid    = 1'b0;
      csr_if.data     = '0;
      drv_pinned      = 1'b0;
      drv_pinned_rsp  = '0;
      gaps_on         = 1'b1;
      hold_off_req    = 1'b0;
      err_count       = 0;
      none            = '0;

      dir_rows.push_back(row(sic_pkg::REQ_READ, 26'h1000, sic_pkg::SIZE_WORD, 0, 0, 1, 0,
                             sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, 26'h4, sic_pkg::SIZE_WORD, 0, 0, 1, 0,
                             sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, 26'h7C, sic_pkg::SIZE_WORD, '1, 0, 1, 0,
                             sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, 26'h0, sic_pkg::SIZE_WORD, 0, 0, 1, 0,
                             sic_pkg::ST_FAULT, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, enable_addr(0), sic_pkg::SIZE_WORD, '1, 0, 1,
                             0, sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, enable_addr(0), sic_pkg::SIZE_WORD, 0, 0, 1,
                             32'hFFFF_FFFE, sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, enable_addr(31), sic_pkg::SIZE_WORD,
                             32'h8000_0001, 0, 1, 0, sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, enable_addr(31), sic_pkg::SIZE_WORD, 0, 0, 1,
                             32'h8000_0000, sic_pkg::ST_OK, 0));
      // enable word past the last context, and one off the stride
      dir_rows.push_back(row(sic_pkg::REQ_READ, enable_addr(32), sic_pkg::SIZE_WORD, 0, 0, 1,
                             0, sic_pkg::ST_FAULT, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, 26'h2004, sic_pkg::SIZE_WORD, 0, 0, 1, 0,
                             sic_pkg::ST_FAULT, 0));
      // update ignores addr, size and wdata
      dir_rows.push_back(row(sic_pkg::REQ_UPDATE, '1, sic_pkg::SIZE_ILLEGAL, '1, '1, 1, 0,
                             sic_pkg::ST_OK, 32'd1));
      dir_rows.push_back(row(sic_pkg::REQ_READ, ctx_addr(0, 1), sic_pkg::SIZE_WORD, 0, 0, 0,
                             0, 0, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, ctx_addr(31, 1) | 26'h3, sic_pkg::SIZE_WORD,
                             0, 0, 0, 0, 0, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, ctx_addr(0, 0), sic_pkg::SIZE_WORD, 0, 0, 1,
                             0, sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, ctx_addr(31, 0), sic_pkg::SIZE_WORD, '1, 0,
                             1, 0, sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, ctx_addr(0, 1), sic_pkg::SIZE_WORD, 1, 0, 1,
                             0, sic_pkg::ST_OK, 0));
      // completion IDs out of range are dropped
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, ctx_addr(0, 1), sic_pkg::SIZE_WORD, 32, 0, 1,
                             0, sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, ctx_addr(0, 1), sic_pkg::SIZE_WORD, '1, 0, 1,
                             0, sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, ctx_addr(32, 1), sic_pkg::SIZE_WORD, 1, 0, 1,
                             0, sic_pkg::ST_FAULT, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, 26'h1000, sic_pkg::SIZE_WORD, '1, 0, 1, 0,
                             sic_pkg::ST_FAULT, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, 26'h1000, SIZE_BYTE, 0, 0, 1, 0,
                             sic_pkg::ST_MISALIGN, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, enable_addr(1), SIZE_HALF, '1, 0, 1, 0,
                             sic_pkg::ST_MISALIGN, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, 26'h1000, sic_pkg::SIZE_ILLEGAL, 0, 0, 1, 0,
                             sic_pkg::ST_ILLEGAL, 0));
      dir_rows.push_back(row(sic_pkg::REQ_WRITE, enable_addr(2), sic_pkg::SIZE_ILLEGAL, '1, 0,
                             1, 0, sic_pkg::ST_ILLEGAL, 0));
      dir_rows.push_back(row(REQ_UNUSED, '1, sic_pkg::SIZE_WORD, '1, '1, 1, 0,
                             sic_pkg::ST_OK, 0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, '1, sic_pkg::SIZE_WORD, 0, 0, 1, 0,
                             sic_pkg::ST_FAULT, 0));
      dir_rows.push_back(row(sic_pkg::REQ_UPDATE, 0, sic_pkg::SIZE_WORD, 0, 32'h2, 0, 0, 0,
                             0));
      dir_rows.push_back(row(sic_pkg::REQ_READ, 26'h1000, sic_pkg::SIZE_WORD, 0, 0, 0, 0, 0,
                             0));

      harts_plan[0] = 6'd1;
      harts_plan[1] = 6'd32;
      harts_plan[2] = 6'd0;
      harts_plan[3] = 6'd63;
      harts_plan[4] = 6'd5;
      harts_plan[5] = 6'($urandom_range(1, 31));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         send_beat(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].rsp, pick_gap());
      end

      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            drain();
            repeat (3) @(posedge clock);
            write_harts(harts_plan[p]);
         end
         gaps_on = (p != 1);
         if (p == 2) begin
            // receiver stalls long while beats keep coming back to back
            gaps_on = 1'b0;
            hold_off_req = 1'b1;
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (p == 2 && n == 150) begin
               gaps_on = 1'b1;
            end
            if (p == 3 && n == PHASE_BEATS / 2) begin
               drain();
            end
            beat = random_beat();
            send_beat(beat, 1'b0, none, pick_gap());
         end
      end

      drain();
      repeat (5) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
